@@ design/dpb_pkg.sv @@
// Shared types and constants for the depth pixel back-projection core.
package dpb_pkg;

	// Field widths fixed by the pixel and point formats
	localparam int DEPTH_W   = 16;
	localparam int PIX_W     = 10;
	localparam int FOCAL_W   = 16;
	localparam int CENTER_W  = 14;
	localparam int COLOR_W   = 8;
	localparam int COORD_W   = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// Back-projection arithmetic
	localparam int ABS_W     = 14;               // |16*pix - centre|
	localparam int MAG_W     = ABS_W + DEPTH_W;  // |numerator|
	localparam int QUO_W     = 32;               // dividend and quotient bits
	localparam int DIVR_W    = FOCAL_W + 1;      // divisor is 2*focal
	localparam int DIV_STEPS = QUO_W;            // one quotient bit per cell

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FOCAL_X   = 3'd0,
		CFG_FOCAL_Y   = 3'd1,
		CFG_CENTER_X  = 3'd2,
		CFG_CENTER_Y  = 3'd3,
		CFG_MIN_DEPTH = 3'd4,
		CFG_MAX_DEPTH = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [FOCAL_W-1:0]  focal_x;
		logic [FOCAL_W-1:0]  focal_y;
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [DEPTH_W-1:0]  min_depth;
		logic [DEPTH_W-1:0]  max_depth;
	} cfg_t;

	// Input pixel transaction
	typedef struct packed {
		logic [DEPTH_W-1:0] depth_value;
		logic               depth_invalid;
		logic [PIX_W-1:0]   pixel_row;
		logic [PIX_W-1:0]   pixel_col;
		logic [COLOR_W-1:0] red_in;
		logic [COLOR_W-1:0] green_in;
		logic [COLOR_W-1:0] blue_in;
	} pix_t;

	// Output point transaction
	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [DEPTH_W-1:0]        point_z;
		logic [COLOR_W-1:0]        red_out;
		logic [COLOR_W-1:0]        green_out;
		logic [COLOR_W-1:0]        blue_out;
	} point_t;

	// Data carried alongside the division
	typedef struct packed {
		logic [DEPTH_W-1:0] z;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} payload_t;

	// Front end result: numerator magnitudes and signs
	typedef struct packed {
		logic [MAG_W-1:0] mag_x;
		logic             neg_x;
		logic             zero_x;
		logic [MAG_W-1:0] mag_y;
		logic             neg_y;
		logic             zero_y;
		payload_t         pay;
	} front_t;

	// One axis of the division: partial remainder and dividend/quotient shifter
	typedef struct packed {
		logic [DIVR_W-1:0] rem;
		logic [QUO_W-1:0]  dq;
		logic              neg;
		logic              zero;
	} lane_t;

	typedef struct packed {
		lane_t    x;
		lane_t    y;
		payload_t pay;
	} div_item_t;

	localparam logic [COORD_W-1:0] COORD_MAX = 24'h7F_FFFF;
	localparam logic [COORD_W-1:0] COORD_MIN = 24'h80_0000;

endpackage

@@ design/dpb_front.sv @@
// Pixel filter and numerator magnitude stages.
module dpb_front #(
	parameter int STRIDE  = 3,
	parameter int MAX_DIM = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dpb_pkg::cfg_t     cfg,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  dpb_pkg::pix_t     pix_data,
	output logic              fr_valid,
	input  logic              fr_ready,
	output dpb_pkg::front_t   fr_item
);

	localparam int RECIP_SHIFT = 16;
	localparam int RECIP       = (2**RECIP_SHIFT + STRIDE - 1) / STRIDE;
	localparam int PROD_W      = dpb_pkg::PIX_W + RECIP_SHIFT + 1;
	localparam int QDIV_W      = PROD_W - RECIP_SHIFT;
	localparam int BACK_W      = QDIV_W + 4;
	localparam int DIM_W       = 13;

	// Multiple of the stride: reciprocal multiply, then multiply back and compare
	function automatic logic stride_hit(input logic [dpb_pkg::PIX_W-1:0] v);
		logic [PROD_W-1:0] prod;
		logic [QDIV_W-1:0] quo;
		logic [BACK_W-1:0] back;
		prod = PROD_W'(v) * PROD_W'(RECIP);
		quo  = prod[PROD_W-1:RECIP_SHIFT];
		back = BACK_W'(quo) * BACK_W'(STRIDE);
		return back == BACK_W'(v);
	endfunction

	// Signed 16*pix - centre, returned as magnitude and sign
	function automatic logic [dpb_pkg::ABS_W:0] centre_offset(
		input logic [dpb_pkg::PIX_W-1:0]    pix,
		input logic [dpb_pkg::CENTER_W-1:0] ctr
	);
		logic signed [15:0] diff;
		logic [15:0]        mag;
		diff = $signed({2'b00, pix, 4'b0000}) - $signed({2'b00, ctr});
		mag  = diff[15] ? (~diff + 16'd1) : diff;
		return {diff[15], mag[dpb_pkg::ABS_W-1:0]};
	endfunction

	logic                        valid_s1, valid_s2;
	logic                        load_s1, load_s2;
	logic                        keep;
	logic [dpb_pkg::ABS_W:0]     offs_x, offs_y;
	logic [dpb_pkg::ABS_W-1:0]   abs_x_s1, abs_y_s1;
	logic                        neg_x_s1, neg_y_s1;
	dpb_pkg::payload_t           pay_s1;
	dpb_pkg::front_t             item_s2;

	// Bubble-collapsing flow control
	assign load_s2   = !valid_s2 || fr_ready;
	assign load_s1   = !valid_s1 || load_s2;
	assign pix_stall = !load_s1;

	// Keep test: flag, image bounds, stride grid and depth window
	assign keep = !pix_data.depth_invalid
		&& ({3'b000, pix_data.pixel_row} < DIM_W'(MAX_DIM))
		&& ({3'b000, pix_data.pixel_col} < DIM_W'(MAX_DIM))
		&& stride_hit(pix_data.pixel_row)
		&& stride_hit(pix_data.pixel_col)
		&& (pix_data.depth_value >= cfg.min_depth)
		&& (pix_data.depth_value <= cfg.max_depth);

	assign offs_x = centre_offset(pix_data.pixel_col, cfg.center_x);
	assign offs_y = centre_offset(pix_data.pixel_row, cfg.center_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= pix_valid && keep;
			if (load_s2) valid_s2 <= valid_s1;
		end
	end

	// Stage 1: centre offsets
	always_ff @(posedge clk) begin
		if (load_s1) begin
			abs_x_s1     <= offs_x[dpb_pkg::ABS_W-1:0];
			neg_x_s1     <= offs_x[dpb_pkg::ABS_W];
			abs_y_s1     <= offs_y[dpb_pkg::ABS_W-1:0];
			neg_y_s1     <= offs_y[dpb_pkg::ABS_W];
			pay_s1.z     <= pix_data.depth_value;
			pay_s1.red   <= pix_data.red_in;
			pay_s1.green <= pix_data.green_in;
			pay_s1.blue  <= pix_data.blue_in;
		end
	end

	// Stage 2: numerator magnitude |offset| * z
	always_ff @(posedge clk) begin
		if (load_s2) begin
			item_s2.mag_x  <= dpb_pkg::MAG_W'(abs_x_s1) * dpb_pkg::MAG_W'(pay_s1.z);
			item_s2.mag_y  <= dpb_pkg::MAG_W'(abs_y_s1) * dpb_pkg::MAG_W'(pay_s1.z);
			item_s2.neg_x  <= neg_x_s1;
			item_s2.neg_y  <= neg_y_s1;
			item_s2.zero_x <= (abs_x_s1 == '0) || (pay_s1.z == '0);
			item_s2.zero_y <= (abs_y_s1 == '0) || (pay_s1.z == '0);
			item_s2.pay    <= pay_s1;
		end
	end

	assign fr_valid = valid_s2;
	assign fr_item  = item_s2;

endmodule

@@ design/dpb_div_cell.sv @@
// One restoring-division cell: one quotient bit per axis.
module dpb_div_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dpb_pkg::DIVR_W-1:0]    divisor_x,
	input  logic [dpb_pkg::DIVR_W-1:0]    divisor_y,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  dpb_pkg::div_item_t            up_item,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output dpb_pkg::div_item_t            dn_item
);

	// Shift in the next dividend bit, subtract the divisor if it fits
	function automatic dpb_pkg::lane_t div_step(
		input dpb_pkg::lane_t              l,
		input logic [dpb_pkg::DIVR_W-1:0]  d
	);
		dpb_pkg::lane_t            r;
		logic [dpb_pkg::DIVR_W:0]  trial;
		logic [dpb_pkg::DIVR_W:0]  diff;
		logic                      ge;
		trial  = {l.rem, l.dq[dpb_pkg::QUO_W-1]};
		diff   = trial - {1'b0, d};
		ge     = trial >= {1'b0, d};
		r      = l;
		r.rem  = ge ? diff[dpb_pkg::DIVR_W-1:0] : trial[dpb_pkg::DIVR_W-1:0];
		r.dq   = {l.dq[dpb_pkg::QUO_W-2:0], ge};
		return r;
	endfunction

	logic               valid_q;
	dpb_pkg::div_item_t item_q;

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			item_q.x   <= div_step(up_item.x, divisor_x);
			item_q.y   <= div_step(up_item.y, divisor_y);
			item_q.pay <= up_item.pay;
		end
	end

	assign dn_valid = valid_q;
	assign dn_item  = item_q;

endmodule

@@ design/dpb_out.sv @@
// Rounding result saturation and output register.
module dpb_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  dpb_pkg::div_item_t  up_item,
	output logic                pt_valid,
	input  logic                pt_stall,
	output dpb_pkg::point_t     pt_data
);

	// Apply the sign and clamp to the 24-bit coordinate range
	function automatic logic [dpb_pkg::COORD_W-1:0] saturate(input dpb_pkg::lane_t l);
		logic [dpb_pkg::COORD_W-1:0] res;
		if (l.zero) begin
			res = '0;
		end else if (!l.neg) begin
			res = (l.dq > dpb_pkg::QUO_W'(dpb_pkg::COORD_MAX)) ?
				dpb_pkg::COORD_MAX : l.dq[dpb_pkg::COORD_W-1:0];
		end else begin
			res = (l.dq > dpb_pkg::QUO_W'(dpb_pkg::COORD_MIN)) ?
				dpb_pkg::COORD_MIN : (~l.dq[dpb_pkg::COORD_W-1:0] + 24'd1);
		end
		return res;
	endfunction

	logic             valid_q;
	dpb_pkg::point_t  data_q;

	assign up_ready = !valid_q || !pt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			data_q.point_x   <= saturate(up_item.x);
			data_q.point_y   <= saturate(up_item.y);
			data_q.point_z   <= up_item.pay.z;
			data_q.red_out   <= up_item.pay.red;
			data_q.green_out <= up_item.pay.green;
			data_q.blue_out  <= up_item.pay.blue;
		end
	end

	assign pt_valid = valid_q;
	assign pt_data  = data_q;

endmodule

@@ design/depth_pixel_backprojection_core.sv @@
// Top level of the depth pixel back-projection core.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------
//  pix     | in        | pix_valid/pix_stall | pix_data  (dpb_pkg::pix_t)
//  pt      | out       | pt_valid/pt_stall   | pt_data   (dpb_pkg::point_t)
//  cfg     | in        | cfg_wen             | cfg_addr, cfg_wdata
//
// One pixel per clock is taken while pix_stall is low; a kept pixel passes two front
// stages, a chain of 32 division cells (one quotient bit each) and the output register.
// Unstalled throughput is one pixel per clock; up to 35 transactions are in flight.
// Reset clears all valid flags and loads the intrinsic and depth window defaults.
// A stalled output lets the chain close up its bubbles, so pixels are still taken
// until every stage holds a transaction; rejected pixels leave no transaction.
module depth_pixel_backprojection_core #(
	parameter int STRIDE  = 3,
	parameter int MAX_DIM = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_valid,
	output logic                              pix_stall,
	input  dpb_pkg::pix_t                     pix_data,
	output logic                              pt_valid,
	input  logic                              pt_stall,
	output dpb_pkg::point_t                   pt_data,
	input  logic                              cfg_wen,
	input  logic [dpb_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [dpb_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

	localparam int N = dpb_pkg::DIV_STEPS;

	dpb_pkg::cfg_t       cfg_q;
	logic                fr_valid;
	dpb_pkg::front_t     fr_item;
	logic                cell_valid [0:N];
	logic                cell_ready [0:N];
	dpb_pkg::div_item_t  cell_item  [0:N];
	logic [dpb_pkg::DIVR_W-1:0] divisor_x, divisor_y;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_x   <= 16'd8400;
			cfg_q.focal_y   <= 16'd8400;
			cfg_q.center_x  <= 14'd5120;
			cfg_q.center_y  <= 14'd3840;
			cfg_q.min_depth <= 16'd82;
			cfg_q.max_depth <= 16'd40960;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				dpb_pkg::CFG_FOCAL_X:   cfg_q.focal_x   <= cfg_wdata;
				dpb_pkg::CFG_FOCAL_Y:   cfg_q.focal_y   <= cfg_wdata;
				dpb_pkg::CFG_CENTER_X:  cfg_q.center_x  <= cfg_wdata[dpb_pkg::CENTER_W-1:0];
				dpb_pkg::CFG_CENTER_Y:  cfg_q.center_y  <= cfg_wdata[dpb_pkg::CENTER_W-1:0];
				dpb_pkg::CFG_MIN_DEPTH: cfg_q.min_depth <= cfg_wdata;
				dpb_pkg::CFG_MAX_DEPTH: cfg_q.max_depth <= cfg_wdata;
				default: ;
			endcase
		end
	end

	dpb_front #(
		.STRIDE  (STRIDE),
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data),
		.fr_valid  (fr_valid),
		.fr_ready  (cell_ready[0]),
		.fr_item   (fr_item)
	);

	// Divisor 2*focal; dividend 2*|num| + focal gives round-half-away
	assign divisor_x = {cfg_q.focal_x, 1'b0};
	assign divisor_y = {cfg_q.focal_y, 1'b0};

	assign cell_valid[0]        = fr_valid;
	assign cell_item[0].x.rem   = '0;
	assign cell_item[0].x.dq    = dpb_pkg::QUO_W'({fr_item.mag_x, 1'b0})
		+ dpb_pkg::QUO_W'(cfg_q.focal_x);
	assign cell_item[0].x.neg   = fr_item.neg_x;
	assign cell_item[0].x.zero  = fr_item.zero_x;
	assign cell_item[0].y.rem   = '0;
	assign cell_item[0].y.dq    = dpb_pkg::QUO_W'({fr_item.mag_y, 1'b0})
		+ dpb_pkg::QUO_W'(cfg_q.focal_y);
	assign cell_item[0].y.neg   = fr_item.neg_y;
	assign cell_item[0].y.zero  = fr_item.zero_y;
	assign cell_item[0].pay     = fr_item.pay;

	// Division chain
	for (genvar i = 0; i < N; i++) begin : g_cell
		dpb_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.divisor_x (divisor_x),
			.divisor_y (divisor_y),
			.up_valid  (cell_valid[i]),
			.up_ready  (cell_ready[i]),
			.up_item   (cell_item[i]),
			.dn_valid  (cell_valid[i+1]),
			.dn_ready  (cell_ready[i+1]),
			.dn_item   (cell_item[i+1])
		);
	end

	dpb_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cell_valid[N]),
		.up_ready (cell_ready[N]),
		.up_item  (cell_item[N]),
		.pt_valid (pt_valid),
		.pt_stall (pt_stall),
		.pt_data  (pt_data)
	);

`ifndef SYNTH
	// Input back-pressure only when the whole path is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (pt_valid && pt_stall))
		else $error("input stalled while the pipeline had room");

	// A new point at the output came from the last division cell
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pt_valid) |-> $past(cell_valid[N]))
		else $error("output became valid without a finished division");

	// A finished division that the output cannot take is kept
	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_valid[N] && !cell_ready[N]) |=> cell_valid[N])
		else $error("division result lost while output was full");
`endif

endmodule
